[rtl/pfi_pkg.sv]
// shared types, constants and helper functions of the particle force integrator
package pfi_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned CW = 31;
  localparam int unsigned CFG_AW = 3;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ATTRACT = 2'd1;
  localparam logic [1:0] CMD_REPEL   = 2'd2;
  localparam logic [1:0] CMD_LOAD    = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_HALF_W = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_HALF_H = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_MASS   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_GAIN   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_LIMIT  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_ORG_X  = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_ORG_Y  = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_ORG_Z  = 3'd7;

  localparam logic [CW-1:0] RST_HALF_W = 31'd33554432;
  localparam logic [CW-1:0] RST_HALF_H = 31'd25165824;
  localparam logic [CW-1:0] RST_GAIN   = 31'd6553600;
  localparam logic [CW-1:0] RST_LIMIT  = 31'd16777216;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned CNT_W      = 6;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK_VEL,
    OP_TICK_EDGE,
    OP_TICK_POS,
    OP_DIFF,
    OP_NORM,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_RF_MUL,
    OP_RF_SAVE,
    OP_GT_MUL,
    OP_DIV_LOAD_STR,
    OP_DIV_STEP,
    OP_STR_SAVE,
    OP_AX_MUL_LO,
    OP_AX_MUL_HI,
    OP_DIV_LOAD_AX,
    OP_AX_ACC,
    OP_SUM_CLR,
    OP_OUT_MUL,
    OP_OUT_ACC,
    OP_LIM_MUL,
    OP_LIM_CMP
  } op_e;

  typedef struct packed {
    logic       capture;
    logic       emit;
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic zero_dist;
  } sts_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [DW+1:0] v);
    logic signed [DW+1:0] hi;
    logic signed [DW+1:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DW-1:0];
    end
  endfunction

  function automatic logic signed [DW-1:0] neg32(input logic signed [DW-1:0] v);
    if (v == 32'sh8000_0000) begin
      neg32 = 32'sh7FFF_FFFF;
    end else begin
      neg32 = -v;
    end
  endfunction

endpackage

[rtl/pfi_if.sv]
// valid/ready channel interfaces for items and results
interface pfi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [30:0]        target_mass;
  logic signed [31:0] init_vx;
  logic signed [31:0] init_vy;
  logic signed [31:0] init_vz;

  modport source (
    output valid, cmd, point_x, point_y, point_z, target_mass, init_vx, init_vy, init_vz,
    input  ready
  );
  modport sink (
    input  valid, cmd, point_x, point_y, point_z, target_mass, init_vx, init_vy, init_vz,
    output ready
  );
endinterface

interface pfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic               outside;
  logic               zero_distance;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, outside, zero_distance,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, outside, zero_distance,
    output ready
  );
endinterface

[rtl/pfi_div.sv]
// restoring divider, 128 by 64 bit, one quotient bit per step, saturating
module pfi_div (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [63:0] hi_i,
  input  logic [63:0] lo_i,
  input  logic [63:0] c_i,
  output logic [63:0] q_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] lo_q, lo_d;
  logic [63:0] q_q, q_d;
  logic [63:0] c_q, c_d;
  logic        sat_q, sat_d;
  logic [63:0] shifted;
  logic        carry;

  always_comb begin
    rem_d   = rem_q;
    lo_d    = lo_q;
    q_d     = q_q;
    c_d     = c_q;
    sat_d   = sat_q;
    carry   = rem_q[63];
    shifted = {rem_q[62:0], lo_q[63]};
    if (load_i) begin
      rem_d = hi_i;
      lo_d  = lo_i;
      q_d   = '0;
      c_d   = c_i;
      sat_d = (hi_i >= c_i);
    end else if (step_i) begin
      lo_d = {lo_q[62:0], 1'b0};
      if (carry || (shifted >= c_q)) begin
        rem_d = shifted - c_q;
        q_d   = {q_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        q_d   = {q_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    q_q   <= q_d;
    c_q   <= c_d;
    sat_q <= sat_d;
  end

  assign q_o = sat_q ? '1 : q_q;

endmodule

[rtl/pfi_dp.sv]
// datapath: particle state, configuration, shared multiplier, square root and divider
module pfi_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfi_pkg::CFG_AW-1:0]    cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  pfi_pkg::cmd_t                 cmd_i,
  output pfi_pkg::sts_t                 sts_o,
  input  logic [1:0]                    item_cmd_i,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  input  logic signed [31:0]            point_z_i,
  input  logic [30:0]                   target_mass_i,
  input  logic signed [31:0]            init_vx_i,
  input  logic signed [31:0]            init_vy_i,
  input  logic signed [31:0]            init_vz_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic signed [31:0]            pos_z_o,
  output logic signed [31:0]            vel_x_o,
  output logic signed [31:0]            vel_y_o,
  output logic signed [31:0]            vel_z_o,
  output logic                          outside_o,
  output logic                          zero_distance_o
);

  // configuration
  logic [30:0]        hw_q, hh_q, gain_q, lim_q;
  logic signed [31:0] org_q [3];

  // particle state
  logic signed [31:0] pos_q [3], pos_d [3];
  logic signed [31:0] vel_q [3], vel_d [3];
  logic signed [31:0] acc_q [3], acc_d [3];

  // captured item
  logic signed [31:0] pt_q [3], pt_d [3];
  logic signed [31:0] iv_q [3], iv_d [3];
  logic [30:0]        tm_q, tm_d;
  logic               repel_q, repel_d;

  // force working registers
  logic signed [32:0] dx_q [3], dx_d [3];
  logic [19:0]        e_q [3], e_d [3];
  logic [3:0]         s_q, s_d;
  logic [63:0]        sum_q, sum_d;
  logic [63:0]        prod_q, prod_d;
  logic [63:0]        plo_q, plo_d;
  logic [63:0]        sx_q, sx_d;
  logic [63:0]        res_q, res_d;
  logic [63:0]        bit_q, bit_d;
  logic [63:0]        c_q, c_d;
  logic [63:0]        str_q, str_d;
  logic               outside_q, outside_d;
  logic               zero_q, zero_d;

  // result register
  logic signed [31:0] opos_q [3];
  logic signed [31:0] ovel_q [3];
  logic               oout_q, ozero_q;

  logic [32:0]        mag [3];
  logic [32:0]        mmax;
  logic [3:0]         s_c;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic               div_load, div_step;
  logic [63:0]        div_hi, div_lo, div_c, div_q;
  logic [127:0]       wide;
  logic [95:0]        full;
  logic [5:0]         kshift;
  logic [63:0]        sqt;
  logic [64:0]        sum65;
  logic signed [32:0] d33;
  logic [32:0]        a33;
  logic [30:0]        am;
  logic signed [33:0] av;
  logic               negf;
  logic signed [32:0] p33, hw33, hh33;

  pfi_div u_div (
    .clk_i  (clk_i),
    .load_i (div_load),
    .step_i (div_step),
    .hi_i   (div_hi),
    .lo_i   (div_lo),
    .c_i    (div_c),
    .q_o    (div_q)
  );

  // magnitudes, largest one and normalizing shift
  always_comb begin
    mmax = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = dx_q[i][32] ? 33'(-dx_q[i]) : 33'(dx_q[i]);
      if (mag[i] > mmax) begin
        mmax = mag[i];
      end
    end
    s_c = 4'd13;
    for (int s = 13; s >= 0; s--) begin
      if ((mmax >> s) < 33'h0_0010_0000) begin
        s_c = 4'(s);
      end
    end
  end

  assign sts_o.zero_dist = (mmax == '0);
  assign mul_p = mul_a * mul_b;

  always_comb begin
    pos_d     = pos_q;
    vel_d     = vel_q;
    acc_d     = acc_q;
    pt_d      = pt_q;
    iv_d      = iv_q;
    tm_d      = tm_q;
    repel_d   = repel_q;
    dx_d      = dx_q;
    e_d       = e_q;
    s_d       = s_q;
    sum_d     = sum_q;
    prod_d    = prod_q;
    plo_d     = plo_q;
    sx_d      = sx_q;
    res_d     = res_q;
    bit_d     = bit_q;
    c_d       = c_q;
    str_d     = str_q;
    outside_d = outside_q;
    zero_d    = zero_q;
    mul_a     = '0;
    mul_b     = '0;
    div_load  = 1'b0;
    div_step  = 1'b0;
    div_hi    = '0;
    div_lo    = '0;
    div_c     = '0;
    kshift    = 6'd36 - 6'({s_q, 1'b0});
    wide      = {64'd0, prod_q} << kshift;
    full      = {prod_q, 32'd0} + {32'd0, plo_q};
    sqt       = res_q + bit_q;
    sum65     = {1'b0, sum_q} + {1'b0, prod_q};
    d33       = {pos_q[cmd_i.axis][31], pos_q[cmd_i.axis]}
              - {org_q[cmd_i.axis][31], org_q[cmd_i.axis]};
    a33       = d33[32] ? 33'(-d33) : 33'(d33);
    am        = (div_q > 64'h0000_0000_7FFF_FFFF) ? '1 : div_q[30:0];
    negf      = dx_q[cmd_i.axis][32] ^ repel_q;
    av        = negf ? -34'(signed'({3'd0, am})) : 34'(signed'({3'd0, am}));
    p33       = '0;
    hw33      = 33'(signed'({2'd0, hw_q}));
    hh33      = 33'(signed'({2'd0, hh_q}));

    if (cmd_i.capture) begin
      pt_d[0] = point_x_i;
      pt_d[1] = point_y_i;
      pt_d[2] = point_z_i;
      iv_d[0] = init_vx_i;
      iv_d[1] = init_vy_i;
      iv_d[2] = init_vz_i;
      tm_d    = target_mass_i;
      repel_d = (item_cmd_i == pfi_pkg::CMD_REPEL);
      zero_d  = 1'b0;
    end

    unique case (cmd_i.op)
      pfi_pkg::OP_NONE: begin
      end
      pfi_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          pos_d[i] = pt_q[i];
          vel_d[i] = iv_q[i];
          acc_d[i] = '0;
        end
      end
      pfi_pkg::OP_TICK_VEL: begin
        for (int i = 0; i < 3; i++) begin
          vel_d[i] = pfi_pkg::sat32(34'(vel_q[i]) + 34'(acc_q[i]));
        end
      end
      pfi_pkg::OP_TICK_EDGE: begin
        p33 = 33'(pos_q[0]);
        if (p33 > hw33) begin
          pos_d[0] = 32'(hw33);
          vel_d[0] = pfi_pkg::neg32(vel_q[0]);
        end else if (p33 < -hw33) begin
          pos_d[0] = 32'(-hw33);
          vel_d[0] = pfi_pkg::neg32(vel_q[0]);
        end else if (33'(pos_q[1]) < -hh33) begin
          pos_d[1] = 32'(-hh33);
          vel_d[1] = pfi_pkg::neg32(vel_q[1]);
        end else if (33'(pos_q[1]) > hh33) begin
          pos_d[1] = 32'(hh33);
          vel_d[1] = pfi_pkg::neg32(vel_q[1]);
        end
      end
      pfi_pkg::OP_TICK_POS: begin
        for (int i = 0; i < 3; i++) begin
          pos_d[i] = pfi_pkg::sat32(34'(pos_q[i]) + 34'(vel_q[i]));
          acc_d[i] = '0;
        end
      end
      pfi_pkg::OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          dx_d[i] = 33'(pt_q[i]) - 33'(pos_q[i]);
        end
      end
      pfi_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          e_d[i] = 20'(mag[i] >> s_c);
        end
        s_d    = s_c;
        sum_d  = '0;
        zero_d = (mmax == '0);
      end
      pfi_pkg::OP_SQ_MUL: begin
        mul_a  = 32'(e_q[cmd_i.axis]);
        mul_b  = 32'(e_q[cmd_i.axis]);
        prod_d = mul_p;
      end
      pfi_pkg::OP_SQ_ACC: begin
        sum_d = sum_q + prod_q;
      end
      pfi_pkg::OP_SQRT_INIT: begin
        sx_d  = sum_q << 20;
        res_d = '0;
        bit_d = 64'h4000_0000_0000_0000;
      end
      pfi_pkg::OP_SQRT_STEP: begin
        if (sx_q >= sqt) begin
          sx_d  = sx_q - sqt;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      pfi_pkg::OP_RF_MUL: begin
        mul_a  = res_q[31:0];
        mul_b  = res_q[31:0];
        prod_d = mul_p;
      end
      pfi_pkg::OP_RF_SAVE: begin
        c_d = prod_q;
      end
      pfi_pkg::OP_GT_MUL: begin
        mul_a  = {1'b0, gain_q};
        mul_b  = {1'b0, tm_q};
        prod_d = mul_p;
      end
      pfi_pkg::OP_DIV_LOAD_STR: begin
        div_load = 1'b1;
        div_hi   = wide[127:64];
        div_lo   = wide[63:0];
        div_c    = c_q;
      end
      pfi_pkg::OP_DIV_STEP: begin
        div_step = 1'b1;
      end
      pfi_pkg::OP_STR_SAVE: begin
        str_d = div_q;
      end
      pfi_pkg::OP_AX_MUL_LO: begin
        mul_a  = str_q[31:0];
        mul_b  = {2'd0, e_q[cmd_i.axis], 10'd0};
        prod_d = mul_p;
      end
      pfi_pkg::OP_AX_MUL_HI: begin
        plo_d  = prod_q;
        mul_a  = str_q[63:32];
        mul_b  = {2'd0, e_q[cmd_i.axis], 10'd0};
        prod_d = mul_p;
      end
      pfi_pkg::OP_DIV_LOAD_AX: begin
        div_load = 1'b1;
        div_hi   = {32'd0, full[95:64]};
        div_lo   = full[63:0];
        div_c    = {32'd0, res_q[31:0]};
      end
      pfi_pkg::OP_AX_ACC: begin
        acc_d[cmd_i.axis] = pfi_pkg::sat32(34'(acc_q[cmd_i.axis]) + av);
      end
      pfi_pkg::OP_SUM_CLR: begin
        sum_d = '0;
      end
      pfi_pkg::OP_OUT_MUL: begin
        mul_a  = a33[31:0];
        mul_b  = a33[31:0];
        prod_d = mul_p;
      end
      pfi_pkg::OP_OUT_ACC: begin
        sum_d = sum65[64] ? '1 : sum65[63:0];
      end
      pfi_pkg::OP_LIM_MUL: begin
        mul_a  = {1'b0, lim_q};
        mul_b  = {1'b0, lim_q};
        prod_d = mul_p;
      end
      pfi_pkg::OP_LIM_CMP: begin
        outside_d = (sum_q > prod_q);
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q   <= pfi_pkg::RST_HALF_W;
      hh_q   <= pfi_pkg::RST_HALF_H;
      gain_q <= pfi_pkg::RST_GAIN;
      lim_q  <= pfi_pkg::RST_LIMIT;
      org_q  <= '{default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfi_pkg::CFG_HALF_W: hw_q     <= cfg_data_i[30:0];
        pfi_pkg::CFG_HALF_H: hh_q     <= cfg_data_i[30:0];
        pfi_pkg::CFG_MASS: begin
          // own mass cancels out of force over mass
        end
        pfi_pkg::CFG_GAIN:   gain_q   <= cfg_data_i[30:0];
        pfi_pkg::CFG_LIMIT:  lim_q    <= cfg_data_i[30:0];
        pfi_pkg::CFG_ORG_X:  org_q[0] <= cfg_data_i;
        pfi_pkg::CFG_ORG_Y:  org_q[1] <= cfg_data_i;
        pfi_pkg::CFG_ORG_Z:  org_q[2] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '{default: '0};
      vel_q <= '{default: '0};
      acc_q <= '{default: '0};
    end else begin
      pos_q <= pos_d;
      vel_q <= vel_d;
      acc_q <= acc_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    pt_q      <= pt_d;
    iv_q      <= iv_d;
    tm_q      <= tm_d;
    repel_q   <= repel_d;
    dx_q      <= dx_d;
    e_q       <= e_d;
    s_q       <= s_d;
    sum_q     <= sum_d;
    prod_q    <= prod_d;
    plo_q     <= plo_d;
    sx_q      <= sx_d;
    res_q     <= res_d;
    bit_q     <= bit_d;
    c_q       <= c_d;
    str_q     <= str_d;
    outside_q <= outside_d;
    zero_q    <= zero_d;
    if (cmd_i.emit) begin
      opos_q  <= pos_q;
      ovel_q  <= vel_q;
      oout_q  <= outside_q;
      ozero_q <= zero_q;
    end
  end

  assign pos_x_o         = opos_q[0];
  assign pos_y_o         = opos_q[1];
  assign pos_z_o         = opos_q[2];
  assign vel_x_o         = ovel_q[0];
  assign vel_y_o         = ovel_q[1];
  assign vel_z_o         = ovel_q[2];
  assign outside_o       = oout_q;
  assign zero_distance_o = ozero_q;

endmodule

[rtl/pfi_ctrl.sv]
// controller: sequences tick, load and force transactions through the datapath
module pfi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     item_cmd_i,
  input  logic           out_ready_i,
  input  pfi_pkg::sts_t  sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output pfi_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_TV, S_TE, S_TP, S_DIFF, S_NORM, S_SQM, S_SQA,
    S_SQRTI, S_SQRT, S_RFM, S_RFS, S_GTM, S_DLS, S_DIVS, S_STRS,
    S_AXL, S_AXH, S_DLA, S_DIVA, S_AXACC, S_OCLR, S_OM, S_OA,
    S_LM, S_LC, S_EMIT
  } state_e;

  localparam logic [pfi_pkg::CNT_W-1:0] SQRT_LAST = pfi_pkg::CNT_W'(pfi_pkg::SQRT_STEPS - 1);
  localparam logic [pfi_pkg::CNT_W-1:0] DIV_LAST  = pfi_pkg::CNT_W'(pfi_pkg::DIV_STEPS - 1);
  localparam logic [1:0]                AX_LAST   = 2'd2;

  state_e                      state_q, state_d;
  logic [pfi_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]                  axis_q, axis_d;
  logic                        ovalid_q, ovalid_d;
  logic                        accept, emit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign emit        = (state_q == S_EMIT) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q + 1'b1;
    axis_d   = axis_q;
    ovalid_d = (ovalid_q && !out_ready_i) || emit;
    cmd_o.capture = accept;
    cmd_o.emit    = emit;
    cmd_o.axis    = axis_q;
    cmd_o.op      = pfi_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (item_cmd_i)
            pfi_pkg::CMD_TICK: state_d = S_TV;
            pfi_pkg::CMD_LOAD: state_d = S_LOAD;
            pfi_pkg::CMD_ATTRACT, pfi_pkg::CMD_REPEL: state_d = S_DIFF;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.op = pfi_pkg::OP_LOAD;
        state_d  = S_OCLR;
      end
      S_TV: begin
        cmd_o.op = pfi_pkg::OP_TICK_VEL;
        state_d  = S_TE;
      end
      S_TE: begin
        cmd_o.op = pfi_pkg::OP_TICK_EDGE;
        state_d  = S_TP;
      end
      S_TP: begin
        cmd_o.op = pfi_pkg::OP_TICK_POS;
        state_d  = S_OCLR;
      end
      S_DIFF: begin
        cmd_o.op = pfi_pkg::OP_DIFF;
        state_d  = S_NORM;
      end
      S_NORM: begin
        cmd_o.op = pfi_pkg::OP_NORM;
        axis_d   = '0;
        state_d  = sts_i.zero_dist ? S_OCLR : S_SQM;
      end
      S_SQM: begin
        cmd_o.op = pfi_pkg::OP_SQ_MUL;
        state_d  = S_SQA;
      end
      S_SQA: begin
        cmd_o.op = pfi_pkg::OP_SQ_ACC;
        if (axis_q == AX_LAST) begin
          state_d = S_SQRTI;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_SQM;
        end
      end
      S_SQRTI: begin
        cmd_o.op = pfi_pkg::OP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = pfi_pkg::OP_SQRT_STEP;
        if (cnt_q == SQRT_LAST) begin
          state_d = S_RFM;
        end
      end
      S_RFM: begin
        cmd_o.op = pfi_pkg::OP_RF_MUL;
        state_d  = S_RFS;
      end
      S_RFS: begin
        cmd_o.op = pfi_pkg::OP_RF_SAVE;
        state_d  = S_GTM;
      end
      S_GTM: begin
        cmd_o.op = pfi_pkg::OP_GT_MUL;
        state_d  = S_DLS;
      end
      S_DLS: begin
        cmd_o.op = pfi_pkg::OP_DIV_LOAD_STR;
        cnt_d    = '0;
        state_d  = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.op = pfi_pkg::OP_DIV_STEP;
        if (cnt_q == DIV_LAST) begin
          state_d = S_STRS;
        end
      end
      S_STRS: begin
        cmd_o.op = pfi_pkg::OP_STR_SAVE;
        axis_d   = '0;
        state_d  = S_AXL;
      end
      S_AXL: begin
        cmd_o.op = pfi_pkg::OP_AX_MUL_LO;
        state_d  = S_AXH;
      end
      S_AXH: begin
        cmd_o.op = pfi_pkg::OP_AX_MUL_HI;
        state_d  = S_DLA;
      end
      S_DLA: begin
        cmd_o.op = pfi_pkg::OP_DIV_LOAD_AX;
        cnt_d    = '0;
        state_d  = S_DIVA;
      end
      S_DIVA: begin
        cmd_o.op = pfi_pkg::OP_DIV_STEP;
        if (cnt_q == DIV_LAST) begin
          state_d = S_AXACC;
        end
      end
      S_AXACC: begin
        cmd_o.op = pfi_pkg::OP_AX_ACC;
        if (axis_q == AX_LAST) begin
          state_d = S_OCLR;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_AXL;
        end
      end
      S_OCLR: begin
        cmd_o.op = pfi_pkg::OP_SUM_CLR;
        axis_d   = '0;
        state_d  = S_OM;
      end
      S_OM: begin
        cmd_o.op = pfi_pkg::OP_OUT_MUL;
        state_d  = S_OA;
      end
      S_OA: begin
        cmd_o.op = pfi_pkg::OP_OUT_ACC;
        if (axis_q == AX_LAST) begin
          state_d = S_LM;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = S_OM;
        end
      end
      S_LM: begin
        cmd_o.op = pfi_pkg::OP_LIM_MUL;
        state_d  = S_LC;
      end
      S_LC: begin
        cmd_o.op = pfi_pkg::OP_LIM_CMP;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      axis_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      axis_q   <= axis_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

[rtl/particle_force_integrator_unit.sv]
// top level of the particle force integrator
//
//  channel  | dir | transaction
//  in_if    | in  | cmd, point_x/y/z, target_mass, init_vx/vy/vz
//  out_if   | out | pos_x/y/z, vel_x/y/z, outside, zero_distance
//  cfg_*    | in  | register write, index and data, no handshake
//
// a load or a tick runs only its own steps and the output sphere check; attract or repel also runs
// the force path, which is skipped when the target sits on the particle; the next item is
// accepted in the idle state after the emit; the force path runs the one-bit-per-cycle
// divider (four 64-step divisions) and the 32-step square root
// one transaction is worked on at a time; a new one is taken while a result waits
// reset clears position, velocity, acceleration and restores register defaults
// a stalled result holds the engine before its result register is overwritten
module particle_force_integrator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pfi_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  pfi_in_if.sink                      in_if,
  pfi_out_if.source                   out_if
);

  pfi_pkg::cmd_t cmd;
  pfi_pkg::sts_t sts;

  pfi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .item_cmd_i  (in_if.cmd),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  pfi_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .item_cmd_i      (in_if.cmd),
    .point_x_i       (in_if.point_x),
    .point_y_i       (in_if.point_y),
    .point_z_i       (in_if.point_z),
    .target_mass_i   (in_if.target_mass),
    .init_vx_i       (in_if.init_vx),
    .init_vy_i       (in_if.init_vy),
    .init_vz_i       (in_if.init_vz),
    .pos_x_o         (out_if.pos_x),
    .pos_y_o         (out_if.pos_y),
    .pos_z_o         (out_if.pos_z),
    .vel_x_o         (out_if.vel_x),
    .vel_y_o         (out_if.vel_y),
    .vel_z_o         (out_if.vel_z),
    .outside_o       (out_if.outside),
    .zero_distance_o (out_if.zero_distance)
  );

endmodule

[bench/particle_force_integrator_unit_tb.sv]
// self-checking testbench of the particle force integrator with its own fixed-point predictor
`timescale 1ns / 100ps

module particle_force_integrator_unit_tb;
  import pfi_pkg::*;

  localparam int WATCHDOG_LIMIT = 12000;
  localparam int HOLD_CYCLES    = 1500;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] px, py, pz;
    logic [30:0]        tmass;
    logic signed [31:0] vx, vy, vz;
  } item_t;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic               outside, zdist;
  } state_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  pfi_in_if  in_if ();
  pfi_out_if out_if ();

  particle_force_integrator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  item_t      pending_items[$];
  state_out_t expected_states[$];
  int errors = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_len = 0;
  int hold_cnt = 0;
  int n_items = 0;
  int n_results = 0;
  int n_zero = 0;
  int n_out = 0;
  int quiet_cycles = 0;
  logic just_took = 1'b0;

  // predictor state and registers
  logic signed [31:0] p_pos[3], p_vel[3], p_acc[3];
  logic [30:0] r_hw = RST_HALF_W, r_hh = RST_HALF_H, r_mass = 31'd65536;
  logic [30:0] r_gain = RST_GAIN, r_lim = RST_LIMIT;
  logic signed [31:0] r_org[3];

  initial begin
    for (int i = 0; i < 3; i++) begin
      p_pos[i] = '0;
      p_vel[i] = '0;
      p_acc[i] = '0;
      r_org[i] = '0;
    end
  end

  function automatic logic signed [31:0] clamp_s32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                                  longint unsigned c);
    logic [127:0] prod;
    logic [127:0] q;
    prod = {64'd0, a} * {64'd0, b};
    if (c == 0 || prod[127:64] >= c) return '1;
    q = prod / {64'd0, c};
    return q[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic beyond_sphere();
    longint d;
    longint unsigned a, sq, sum, lim2;
    sum = 0;
    lim2 = longint'(r_lim) * longint'(r_lim);
    for (int i = 0; i < 3; i++) begin
      d = longint'(p_pos[i]) - longint'(r_org[i]);
      a = (d < 0) ? longint'(-d) : longint'(d);
      if (a >= 64'd4294967296) return 1'b1;
      sq = a * a;
      sum = (sum > ~sq) ? '1 : sum + sq;
    end
    return sum > lim2;
  endfunction

  function automatic logic add_pull(item_t it, logic repel);
    longint d[3];
    longint unsigned e[3];
    longint unsigned m, ssum, rf, str, am;
    longint a;
    int s;
    logic signed [31:0] tgt[3];
    tgt[0] = it.px;
    tgt[1] = it.py;
    tgt[2] = it.pz;
    m = 0;
    ssum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(tgt[i]) - longint'(p_pos[i]);
      e[i] = (d[i] < 0) ? longint'(-d[i]) : longint'(d[i]);
      if (e[i] > m) m = e[i];
    end
    if (m == 0) return 1'b1;
    while ((m >> s) >= (64'd1 << 20)) s++;
    for (int i = 0; i < 3; i++) begin
      e[i] = e[i] >> s;
      ssum += e[i] * e[i];
    end
    rf = int_sqrt(ssum << 20);
    str = scaled_quot(longint'(r_gain) * longint'(it.tmass), 64'd1 << (36 - 2 * s), rf * rf);
    for (int i = 0; i < 3; i++) begin
      am = scaled_quot(str, e[i] << 10, rf);
      if (am > 64'h7FFF_FFFF) am = 64'h7FFF_FFFF;
      a = longint'(am);
      if (d[i] < 0) a = -a;
      if (repel) a = -a;
      p_acc[i] = clamp_s32(longint'(p_acc[i]) + a);
    end
    return 1'b0;
  endfunction

  function automatic void advance_tick();
    longint hw, hh;
    hw = longint'(r_hw);
    hh = longint'(r_hh);
    for (int i = 0; i < 3; i++) p_vel[i] = clamp_s32(longint'(p_vel[i]) + longint'(p_acc[i]));
    if (p_pos[0] > hw) begin
      p_pos[0] = clamp_s32(hw);
      p_vel[0] = clamp_s32(-longint'(p_vel[0]));
    end else if (p_pos[0] < -hw) begin
      p_pos[0] = clamp_s32(-hw);
      p_vel[0] = clamp_s32(-longint'(p_vel[0]));
    end else if (p_pos[1] < -hh) begin
      p_pos[1] = clamp_s32(-hh);
      p_vel[1] = clamp_s32(-longint'(p_vel[1]));
    end else if (p_pos[1] > hh) begin
      p_pos[1] = clamp_s32(hh);
      p_vel[1] = clamp_s32(-longint'(p_vel[1]));
    end
    for (int i = 0; i < 3; i++) begin
      p_pos[i] = clamp_s32(longint'(p_pos[i]) + longint'(p_vel[i]));
      p_acc[i] = '0;
    end
  endfunction

  function automatic state_out_t predict_state(item_t it);
    state_out_t r;
    r.zdist = 1'b0;
    case (it.cmd)
      CMD_TICK: advance_tick();
      CMD_LOAD: begin
        p_pos[0] = it.px;
        p_pos[1] = it.py;
        p_pos[2] = it.pz;
        p_vel[0] = it.vx;
        p_vel[1] = it.vy;
        p_vel[2] = it.vz;
        for (int i = 0; i < 3; i++) p_acc[i] = '0;
      end
      default: r.zdist = add_pull(it, it.cmd == CMD_REPEL);
    endcase
    r.px = p_pos[0];
    r.py = p_pos[1];
    r.pz = p_pos[2];
    r.vx = p_vel[0];
    r.vy = p_vel[1];
    r.vz = p_vel[2];
    r.outside = beyond_sphere();
    return r;
  endfunction

  // clock and reset
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // item driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (pending_items.size() > 0 &&
                 ((in_if.valid && !just_took) || $urandom_range(99) >= in_idle_pct)) begin
      in_if.valid       <= 1'b1;
      in_if.cmd         <= pending_items[0].cmd;
      in_if.point_x     <= pending_items[0].px;
      in_if.point_y     <= pending_items[0].py;
      in_if.point_z     <= pending_items[0].pz;
      in_if.target_mass <= pending_items[0].tmass;
      in_if.init_vx     <= pending_items[0].vx;
      in_if.init_vy     <= pending_items[0].vy;
      in_if.init_vz     <= pending_items[0].vz;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = CMD_TICK;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    in_if.target_mass = '0;
    in_if.init_vx = '0;
    in_if.init_vy = '0;
    in_if.init_vz = '0;
    out_if.ready = 1'b0;
  end

  // result receiver with a long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt < hold_len) begin
      hold_cnt <= hold_cnt + 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // accepted transactions on both channels
  always @(posedge clk_i) begin
    state_out_t exp_s;
    just_took <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      quiet_cycles <= ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) ?
                      0 : quiet_cycles + 1;
      if (in_if.valid && in_if.ready) begin
        expected_states.push_back(predict_state(pending_items.pop_front()));
        n_items++;
      end
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_states.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          exp_s = expected_states.pop_front();
          if (out_if.outside) n_out++;
          if (out_if.zero_distance) n_zero++;
          if (out_if.pos_x !== exp_s.px) begin
            $error("pos_x expected %0d got %0d", exp_s.px, out_if.pos_x); errors++;
          end
          if (out_if.pos_y !== exp_s.py) begin
            $error("pos_y expected %0d got %0d", exp_s.py, out_if.pos_y); errors++;
          end
          if (out_if.pos_z !== exp_s.pz) begin
            $error("pos_z expected %0d got %0d", exp_s.pz, out_if.pos_z); errors++;
          end
          if (out_if.vel_x !== exp_s.vx) begin
            $error("vel_x expected %0d got %0d", exp_s.vx, out_if.vel_x); errors++;
          end
          if (out_if.vel_y !== exp_s.vy) begin
            $error("vel_y expected %0d got %0d", exp_s.vy, out_if.vel_y); errors++;
          end
          if (out_if.vel_z !== exp_s.vz) begin
            $error("vel_z expected %0d got %0d", exp_s.vz, out_if.vel_z); errors++;
          end
          if (out_if.outside !== exp_s.outside) begin
            $error("outside expected %0d got %0d", exp_s.outside, out_if.outside); errors++;
          end
          if (out_if.zero_distance !== exp_s.zdist) begin
            $error("zero_distance expected %0d got %0d", exp_s.zdist, out_if.zero_distance);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_HALF_W: r_hw = data[30:0];
      CFG_HALF_H: r_hh = data[30:0];
      CFG_MASS:   r_mass = data[30:0];
      CFG_GAIN:   r_gain = data[30:0];
      CFG_LIMIT:  r_lim = data[30:0];
      CFG_ORG_X:  r_org[0] = data;
      CFG_ORG_Y:  r_org[1] = data;
      default:    r_org[2] = data;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coord();
    int k;
    k = $urandom_range(15);
    if (k == 0) return 32'sh7FFF_FFFF;
    if (k == 1) return 32'sh8000_0000;
    if (k < 5) return $urandom;
    return $signed($urandom_range(2 * 33554432)) - 32'sd33554432;
  endfunction

  function automatic logic [30:0] pick_mass();
    int k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 4) return 31'($urandom);
    return 31'($urandom_range(20 * 65536));
  endfunction

  task automatic queue_item(logic [1:0] cmd, logic signed [31:0] x, y, z,
                            logic [30:0] tm, logic signed [31:0] vx, vy, vz);
    item_t it;
    it.cmd = cmd;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.tmass = tm;
    it.vx = vx;
    it.vy = vy;
    it.vz = vz;
    pending_items.push_back(it);
  endtask

  task automatic queue_random(logic [1:0] cmd);
    queue_item(cmd, pick_coord(), pick_coord(), pick_coord(), pick_mass(),
               pick_coord() >>> $urandom_range(8), pick_coord() >>> $urandom_range(8),
               pick_coord() >>> $urandom_range(8));
  endtask

  // load, then two to eight pulls, ticks or raw random items; sometimes a pull at the loaded spot first
  task automatic queue_burst();
    item_t ld;
    int k;
    queue_random(CMD_LOAD);
    ld = pending_items[$];
    if ($urandom_range(3) == 0)
      queue_item(CMD_ATTRACT, ld.px, ld.py, ld.pz, pick_mass(), $urandom, $urandom, $urandom);
    k = $urandom_range(8, 2);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(9))
        0, 1, 2:    queue_random(CMD_ATTRACT);
        3, 4:       queue_random(CMD_REPEL);
        5:          queue_item(2'($urandom), $urandom, $urandom, $urandom, 31'($urandom),
                               $urandom, $urandom, $urandom);
        default:    queue_random(CMD_TICK);
      endcase
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_states.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int burst_target;
    @(posedge rst_ni);
    // directed: extremes, each command, zero distance, every edge and saturation
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, '0,
               32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_ATTRACT, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, 0, 0, 0);
    queue_item(CMD_REPEL, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, 0, 0, 0);
    queue_item(CMD_LOAD, 65536, 131072, -65536, '0, 0, 0, 0);
    queue_item(CMD_ATTRACT, 65536, 131072, -65536, 31'd65536, 0, 0, 0);
    queue_item(CMD_ATTRACT, 65536 * 10, 131072, -65536, 31'd65536, 0, 0, 0);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_REPEL, 65536 * 3, 65536 * 7, 65536 * 2, 31'd655360, 0, 0, 0);
    queue_item(CMD_ATTRACT, 65537, 131072, -65536, 31'h7FFF_FFFF, 0, 0, 0);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 32'sd33554433, 0, 0, '0, 32'sd100, 32'sd5, 0);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, -32'sd33554433, 32'sd30000000, 0, '0, -32'sd100, 0, 0);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 0, -32'sd25165825, 0, '0, 0, 32'sh8000_0000, 0);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 0, 32'sd25165825, 32'sd20000000, '0, 0, 32'sd7, 0);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    queue_item(CMD_LOAD, 0, 0, 0, '0, 0, 0, 0);
    queue_item(CMD_ATTRACT, 1, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);
    queue_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_HALF_W, $urandom);
          write_reg(CFG_HALF_H, $urandom);
          write_reg(CFG_MASS, $urandom);
          write_reg(CFG_GAIN, $urandom);
          write_reg(CFG_LIMIT, $urandom);
          write_reg(CFG_ORG_X, $urandom);
          write_reg(CFG_ORG_Y, $urandom);
          write_reg(CFG_ORG_Z, $urandom);
        end
        2: begin
          write_reg(CFG_HALF_W, 32'd0);
          write_reg(CFG_HALF_H, 32'd0);
          write_reg(CFG_MASS, 32'd1);
          write_reg(CFG_GAIN, 32'h7FFF_FFFF);
          write_reg(CFG_LIMIT, 32'd0);
          write_reg(CFG_ORG_X, 32'h8000_0000);
          write_reg(CFG_ORG_Y, 32'h7FFF_FFFF);
          write_reg(CFG_ORG_Z, 32'h8000_0000);
        end
        3: begin
          write_reg(CFG_HALF_W, 32'h7FFF_FFFF);
          write_reg(CFG_HALF_H, 32'h7FFF_FFFF);
          write_reg(CFG_MASS, 32'hFFFF_FFFF);
          write_reg(CFG_GAIN, 32'd0);
          write_reg(CFG_LIMIT, 32'h7FFF_FFFF);
          write_reg(CFG_ORG_X, 32'd0);
          write_reg(CFG_ORG_Y, 32'd0);
          write_reg(CFG_ORG_Z, 32'd0);
        end
        4: begin
          write_reg(CFG_HALF_W, 32'd33554432);
          write_reg(CFG_HALF_H, 32'd25165824);
          write_reg(CFG_GAIN, 32'd6553600);
          write_reg(CFG_LIMIT, 32'd16777216);
        end
        default: ;
      endcase
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 65; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 65; end
        default: begin in_idle_pct = 10; out_stall_pct = 10; end
      endcase
      burst_target = pending_items.size() + 130;
      while (pending_items.size() < burst_target) queue_burst();
      if (ph == 1) hold_len = hold_cnt + HOLD_CYCLES;
      drain();
    end
    repeat (400) @(posedge clk_i);
    $display("run covered %0d items and %0d results over six register settings,", n_items,
             n_results);
    $display("with %0d zero-distance and %0d outside-sphere results", n_zero, n_out);
    if (errors == 0 && expected_states.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
